### hw/rtl/ihex_pkg.sv
package ihex_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned KindW  = 4;
  localparam int unsigned AddrW  = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned TotalW = 16;
  localparam int unsigned DataW  = AddrW + ByteW + AddrW + ByteW + TotalW + ByteW;

  localparam logic [CharW-1:0] ChCr    = 8'h0D;
  localparam logic [CharW-1:0] ChLf    = 8'h0A;
  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChEof   = 8'h1A;

  typedef enum logic [KindW-1:0] {
    KIND_DATA      = 4'd0,
    KIND_REC_OK    = 4'd1,
    KIND_CHK_BAD   = 4'd2,
    KIND_END_REC   = 4'd3,
    KIND_NO_END    = 4'd4,
    KIND_BAD_HEX   = 4'd5,
    KIND_EOF_IN    = 4'd6,
    KIND_IGN_TYPE  = 4'd7,
    KIND_START_BAD = 4'd8
  } ihex_kind_t;

  typedef enum logic [ByteW-1:0] {
    REC_DATA = 8'h00,
    REC_EOF  = 8'h01
  } ihex_rtype_t;

  // packed with the first output field in the low bits
  typedef struct packed {
    logic [ByteW-1:0]  checksum_sum;
    logic [TotalW-1:0] byte_total;
    logic [ByteW-1:0]  record_type;
    logic [AddrW-1:0]  record_address;
    logic [ByteW-1:0]  data_byte;
    logic [AddrW-1:0]  load_offset;
  } ihex_data_t;

  typedef struct packed {
    ihex_kind_t kind;
    ihex_data_t data;
  } ihex_result_t;

  // bit 4 set: not a hex digit
  function automatic logic [4:0] hex_value(input logic [CharW-1:0] c);
    logic [CharW-1:0] lc;
    lc = c;
    if (c >= 8'h41 && c <= 8'h46) lc = c + 8'h20;
    if (lc >= 8'h30 && lc <= 8'h39) return {1'b0, 4'(lc - 8'h30)};
    if (lc >= 8'h61 && lc <= 8'h66) return {1'b0, 4'(lc - 8'h61 + 8'd10)};
    return 5'h10;
  endfunction

endpackage

### hw/rtl/ihex_core.sv
module ihex_core
  import ihex_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [AddrW-1:0]    cfg_data,
  input  logic                item_en,
  input  logic [CharW-1:0]    item_char,
  output logic                res_valid,
  output ihex_result_t        res
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_COUNT, PH_ADDR, PH_TYPE, PH_DATA, PH_CHK, PH_SKIP, PH_DONE
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic               hi_pend_r, hi_pend_nxt;
  logic [3:0]         nib_r, nib_nxt;
  logic               fidx_r, fidx_nxt;
  logic [ByteW-1:0]   count_r, count_nxt;
  logic [ByteW-1:0]   left_r, left_nxt;
  logic [AddrW-1:0]   addr_r, addr_nxt;
  logic [ByteW-1:0]   type_r, type_nxt;
  logic [ByteW-1:0]   sum_r, sum_nxt;
  logic               first_r, first_nxt;
  logic [AddrW-1:0]   first_addr_r, first_addr_nxt;
  logic [AddrW-1:0]   offset_r, offset_nxt;
  logic [TotalW-1:0]  total_r, total_nxt;
  logic [AddrW-1:0]   exp_start_r;

  logic [4:0]         hv;
  logic [ByteW-1:0]   b;
  logic [ByteW-1:0]   sum_b;
  logic [TotalW:0]    total_sum;
  logic [AddrW-1:0]   addr_full;
  logic               eol;
  logic               emit;
  ihex_kind_t         kind;
  logic [AddrW-1:0]   off;
  logic [ByteW-1:0]   dbyte;

  assign hv        = hex_value(item_char);
  assign b         = {nib_r, hv[3:0]};
  assign sum_b     = sum_r + b;
  assign total_sum = {1'b0, total_r} + {{(TotalW+1-ByteW){1'b0}}, count_r};
  assign addr_full = {addr_r[AddrW-1:ByteW], b};
  assign eol       = (item_char == ChCr) || (item_char == ChLf);

  always_comb begin
    phase_nxt      = phase_r;
    hi_pend_nxt    = hi_pend_r;
    nib_nxt        = nib_r;
    fidx_nxt       = fidx_r;
    count_nxt      = count_r;
    left_nxt       = left_r;
    addr_nxt       = addr_r;
    type_nxt       = type_r;
    sum_nxt        = sum_r;
    first_nxt      = first_r;
    first_addr_nxt = first_addr_r;
    offset_nxt     = offset_r;
    total_nxt      = total_r;
    emit           = 1'b0;
    kind           = KIND_DATA;
    off            = '0;
    dbyte          = '0;
    unique case (phase_r)
      PH_IDLE: begin
        if (item_char == ChEof) begin
          phase_nxt = PH_DONE;
          emit      = 1'b1;
          kind      = KIND_NO_END;
        end else if (!eol && item_char != ChSpace) begin
          phase_nxt   = PH_COUNT;
          hi_pend_nxt = 1'b0;
          fidx_nxt    = 1'b0;
          count_nxt   = '0;
          left_nxt    = '0;
          addr_nxt    = '0;
          type_nxt    = '0;
          sum_nxt     = '0;
        end
      end
      PH_SKIP: begin
        if (item_char == ChEof) begin
          phase_nxt = PH_DONE;
          emit      = 1'b1;
          kind      = KIND_NO_END;
        end else if (eol) begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_DONE: ;
      default: begin
        if (item_char == ChEof) begin
          phase_nxt = PH_DONE;
          emit      = 1'b1;
          kind      = KIND_EOF_IN;
        end else if (hv[4]) begin
          hi_pend_nxt = 1'b0;
          phase_nxt   = eol ? PH_IDLE : PH_SKIP;
          emit        = 1'b1;
          kind        = KIND_BAD_HEX;
        end else if (!hi_pend_r) begin
          nib_nxt     = hv[3:0];
          hi_pend_nxt = 1'b1;
        end else begin
          hi_pend_nxt = 1'b0;
          sum_nxt     = sum_b;
          unique case (phase_r)
            PH_COUNT: begin
              count_nxt = b;
              left_nxt  = b;
              fidx_nxt  = 1'b0;
              phase_nxt = PH_ADDR;
            end
            PH_ADDR: begin
              if (!fidx_r) begin
                addr_nxt = {b, {ByteW{1'b0}}};
                fidx_nxt = 1'b1;
              end else begin
                addr_nxt  = addr_full;
                fidx_nxt  = 1'b0;
                phase_nxt = PH_TYPE;
                if (first_r) begin
                  first_nxt      = 1'b0;
                  first_addr_nxt = addr_full;
                  offset_nxt     = '0;
                  if (exp_start_r != '0 && exp_start_r != addr_full) begin
                    emit = 1'b1;
                    kind = KIND_START_BAD;
                  end
                end else begin
                  offset_nxt = addr_full - first_addr_r;
                end
              end
            end
            PH_TYPE: begin
              type_nxt = b;
              if (b == REC_DATA) begin
                phase_nxt = (left_r != '0) ? PH_DATA : PH_CHK;
              end else if (b == REC_EOF) begin
                phase_nxt = PH_DONE;
                emit      = 1'b1;
                kind      = KIND_END_REC;
              end else begin
                phase_nxt = PH_SKIP;
                emit      = 1'b1;
                kind      = KIND_IGN_TYPE;
              end
            end
            PH_DATA: begin
              offset_nxt = offset_r + 1'b1;
              left_nxt   = left_r - 1'b1;
              if (left_r == 8'd1) phase_nxt = PH_CHK;
              emit  = 1'b1;
              kind  = KIND_DATA;
              off   = offset_r;
              dbyte = b;
            end
            default: begin
              phase_nxt = PH_IDLE;
              emit      = 1'b1;
              if (sum_b == '0) begin
                total_nxt = total_sum[TotalW] ? '1 : total_sum[TotalW-1:0];
                kind      = KIND_REC_OK;
              end else begin
                kind      = KIND_CHK_BAD;
              end
            end
          endcase
        end
      end
    endcase
  end

  assign res_valid = item_en && emit;
  assign res.kind  = kind;
  assign res.data  = '{checksum_sum:   sum_nxt,
                       byte_total:     total_nxt,
                       record_type:    type_nxt,
                       record_address: addr_nxt,
                       data_byte:      dbyte,
                       load_offset:    off};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      hi_pend_r    <= 1'b0;
      nib_r        <= '0;
      fidx_r       <= 1'b0;
      count_r      <= '0;
      left_r       <= '0;
      addr_r       <= '0;
      type_r       <= '0;
      sum_r        <= '0;
      first_r      <= 1'b1;
      first_addr_r <= '0;
      offset_r     <= '0;
      total_r      <= '0;
      exp_start_r  <= '0;
    end else begin
      if (cfg_we) exp_start_r <= cfg_data;
      if (item_en) begin
        phase_r      <= phase_nxt;
        hi_pend_r    <= hi_pend_nxt;
        nib_r        <= nib_nxt;
        fidx_r       <= fidx_nxt;
        count_r      <= count_nxt;
        left_r       <= left_nxt;
        addr_r       <= addr_nxt;
        type_r       <= type_nxt;
        sum_r        <= sum_nxt;
        first_r      <= first_nxt;
        first_addr_r <= first_addr_nxt;
        offset_r     <= offset_nxt;
        total_r      <= total_nxt;
      end
    end
  end

endmodule

### hw/rtl/ihex_out_buf.sv
module ihex_out_buf
  import ihex_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ihex_result_t  push_res,
  output logic          room,
  output logic          out_valid,
  input  logic          out_ready,
  output ihex_result_t  out_res
);

  logic          main_v_r;
  logic          skid_v_r;
  ihex_result_t  main_r;
  ihex_result_t  skid_r;
  logic          pop;

  assign pop       = main_v_r && out_ready;
  assign room      = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_res   = main_r;

  // push only happens while the skid entry is free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!main_v_r || pop) begin
      if (skid_v_r) begin
        main_v_r <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        main_v_r <= push;
      end
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_v_r || pop) begin
      if (skid_v_r) main_r <= skid_r;
      else if (push) main_r <= push_res;
    end else if (push) begin
      skid_r <= push_res;
    end
  end

endmodule

### hw/rtl/intel_hex_record_parser.sv
// Intel HEX record parser. One character enters per cycle on in_* while
// in_tready is high; the parser state is updated in that cycle and any result
// (data byte, record verdict or error) is written into a two-entry output
// buffer. in_tready falls only while both buffer entries hold results that the
// sink has not taken. After an end record or end of file, characters are
// consumed without results until reset. The user writes expected_start via
// cfg_wr_en only while no character is in flight; the block does not enforce it.
module intel_hex_record_parser
  import ihex_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [AddrW-1:0]   cfg_wr_data,   // expected_start
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [CharW-1:0]   in_tdata,      // char_code
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [DataW-1:0]   out_tdata,     // load_offset, data_byte, record_address,
                                            // record_type, byte_total, checksum_sum
  output logic [KindW-1:0]   out_tuser      // result_kind
);

  logic          accept;
  logic          res_valid;
  ihex_result_t  res;
  ihex_result_t  out_res;

  assign accept = in_tvalid && in_tready;

  ihex_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_wr_en),
    .cfg_data  (cfg_wr_data),
    .item_en   (accept),
    .item_char (in_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  ihex_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_res  (res),
    .room      (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = out_res.data;
  assign out_tuser = out_res.kind;

endmodule

### hw/rtl/ihex_chk.sv
module ihex_chk
  import ihex_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic [DataW-1:0]   out_tdata,
  input  logic [KindW-1:0]   out_tuser
);

  ihex_data_t d;
  assign d = out_tdata;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result dropped or changed while stalled");

  a_data_type: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_DATA |-> d.record_type == REC_DATA)
    else $error("data item outside a data record");

  a_sum_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_REC_OK |-> d.checksum_sum == '0)
    else $error("good record with nonzero sum");

  a_sum_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_CHK_BAD |-> d.checksum_sum != '0)
    else $error("bad record with zero sum");

  a_end_type: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_END_REC |-> d.record_type == REC_EOF)
    else $error("end record item with wrong type");

endmodule

bind intel_hex_record_parser ihex_chk u_ihex_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

### tb/intel_hex_record_parser_test.sv
module intel_hex_record_parser_test;
  import ihex_pkg::*;

  localparam int QuietLimit = 2000;
  localparam int SettleCycles = 8;
  localparam int PhaseChars = 420;

  typedef enum logic [3:0] {
    ST_IDLE, ST_COUNT, ST_ADDR, ST_TYPE, ST_DATA, ST_CHK, ST_SKIP, ST_DONE
  } parse_state_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en = 1'b0;
  logic [AddrW-1:0] cfg_wr_data = '0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [CharW-1:0] in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [DataW-1:0] out_tdata;
  logic [KindW-1:0] out_tuser;

  intel_hex_record_parser u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int error_count = 0;
  int chars_sent = 0;
  int quiet_cycles = 0;

  // parser shadow state
  parse_state_t ps = ST_IDLE;
  logic         nib_pending = 1'b0;
  logic [3:0]   nib_hi = '0;
  logic         addr_lo_next = 1'b0;
  logic [7:0]   rec_count = '0;
  logic [7:0]   rec_left = '0;
  logic [15:0]  rec_addr = '0;
  logic [7:0]   rec_type = '0;
  logic [7:0]   rec_sum = '0;
  logic         first_rec = 1'b1;
  logic [15:0]  base_addr = '0;
  logic [15:0]  next_offset = '0;
  logic [15:0]  good_bytes = '0;
  logic [15:0]  start_addr_cfg = '0;

  ihex_result_t hex_results_q[$];

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= 100) $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s: got %h, expected %h", name, got, want));
  endtask

  function automatic logic [4:0] char_nibble(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, 4'(c - 8'h30)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b0, 4'(c - 8'h41 + 8'd10)};
    if (c >= 8'h61 && c <= 8'h66) return {1'b0, 4'(c - 8'h61 + 8'd10)};
    return 5'h10;
  endfunction

  task automatic push_result(input ihex_kind_t k, input logic [15:0] off,
                             input logic [7:0] d);
    ihex_result_t r;
    r.kind = k;
    r.data.load_offset = off;
    r.data.data_byte = d;
    r.data.record_address = rec_addr;
    r.data.record_type = rec_type;
    r.data.byte_total = good_bytes;
    r.data.checksum_sum = rec_sum;
    hex_results_q.push_back(r);
  endtask

  task automatic parse_char(input logic [7:0] c);
    logic       eol;
    logic [4:0] nib;
    logic [7:0] b;
    logic [16:0] total;
    eol = (c == ChCr || c == ChLf);
    nib = char_nibble(c);
    case (ps)
      ST_IDLE: begin
        if (c == ChEof) begin
          ps = ST_DONE;
          push_result(KIND_NO_END, '0, '0);
        end else if (!eol && c != ChSpace) begin
          ps = ST_COUNT;
          nib_pending = 1'b0;
          addr_lo_next = 1'b0;
          rec_count = '0;
          rec_left = '0;
          rec_addr = '0;
          rec_type = '0;
          rec_sum = '0;
        end
      end
      ST_SKIP: begin
        if (c == ChEof) begin
          ps = ST_DONE;
          push_result(KIND_NO_END, '0, '0);
        end else if (eol) begin
          ps = ST_IDLE;
        end
      end
      ST_DONE: ;
      default: begin
        if (c == ChEof) begin
          ps = ST_DONE;
          push_result(KIND_EOF_IN, '0, '0);
        end else if (nib[4]) begin
          nib_pending = 1'b0;
          ps = eol ? ST_IDLE : ST_SKIP;
          push_result(KIND_BAD_HEX, '0, '0);
        end else if (!nib_pending) begin
          nib_hi = nib[3:0];
          nib_pending = 1'b1;
        end else begin
          nib_pending = 1'b0;
          b = {nib_hi, nib[3:0]};
          rec_sum = rec_sum + b;
          case (ps)
            ST_COUNT: begin
              rec_count = b;
              rec_left = b;
              addr_lo_next = 1'b0;
              ps = ST_ADDR;
            end
            ST_ADDR: begin
              if (!addr_lo_next) begin
                rec_addr = {b, 8'h00};
                addr_lo_next = 1'b1;
              end else begin
                rec_addr[7:0] = b;
                addr_lo_next = 1'b0;
                ps = ST_TYPE;
                if (first_rec) begin
                  first_rec = 1'b0;
                  base_addr = rec_addr;
                  next_offset = '0;
                  if (start_addr_cfg != 0 && start_addr_cfg != rec_addr)
                    push_result(KIND_START_BAD, '0, '0);
                end else begin
                  next_offset = rec_addr - base_addr;
                end
              end
            end
            ST_TYPE: begin
              rec_type = b;
              if (b == REC_DATA) begin
                ps = (rec_left != 0) ? ST_DATA : ST_CHK;
              end else if (b == REC_EOF) begin
                ps = ST_DONE;
                push_result(KIND_END_REC, '0, '0);
              end else begin
                ps = ST_SKIP;
                push_result(KIND_IGN_TYPE, '0, '0);
              end
            end
            ST_DATA: begin
              push_result(KIND_DATA, next_offset, b);
              next_offset = next_offset + 16'd1;
              rec_left = rec_left - 8'd1;
              if (rec_left == 0) ps = ST_CHK;
            end
            ST_CHK: begin
              ps = ST_IDLE;
              if (rec_sum == 0) begin
                total = {1'b0, good_bytes} + rec_count;
                good_bytes = total[16] ? 16'hFFFF : total[15:0];
                push_result(KIND_REC_OK, '0, '0);
              end else begin
                push_result(KIND_CHK_BAD, '0, '0);
              end
            end
            default: ;
          endcase
        end
      end
    endcase
  endtask

  always @(negedge clk) begin
    out_tready = ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin : check_results
    ihex_result_t want;
    ihex_data_t   got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (hex_results_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result, kind %0d", out_tuser));
      end else begin
        want = hex_results_q.pop_front();
        check_field("result_kind", 16'(out_tuser), 16'(want.kind));
        check_field("load_offset", got.load_offset, want.data.load_offset);
        check_field("data_byte", 16'(got.data_byte), 16'(want.data.data_byte));
        check_field("record_address", got.record_address, want.data.record_address);
        check_field("record_type", 16'(got.record_type), 16'(want.data.record_type));
        check_field("byte_total", got.byte_total, want.data.byte_total);
        check_field("checksum_sum", 16'(got.checksum_sum), 16'(want.data.checksum_sum));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid = 1'b0;
      in_tdata = 8'($urandom);
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = c;
    do @(posedge clk); while (!in_tready);
    parse_char(c);
    chars_sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic wait_results_drained();
    while (hex_results_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_expected_start(input logic [15:0] v);
    wait_results_drained();
    cfg_wr_en = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    start_addr_cfg = v;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 10) return {4'h0, n} + 8'h30;
    return {4'h0, n} - 8'd10 + ($urandom_range(1) ? 8'h41 : 8'h61);
  endfunction

  // not hex, not end of file; at least half of them end the line
  function automatic logic [7:0] bad_char();
    logic [7:0] c;
    if ($urandom_range(1)) return $urandom_range(1) ? ChCr : ChLf;
    do c = 8'($urandom_range(255)); while (char_nibble(c) != 5'h10 || c == ChEof);
    return c;
  endfunction

  // break_pos > 0 cuts the line there and puts break_char in its place
  task automatic send_record(input logic [7:0] cnt, input logic [15:0] addr,
                             input logic [7:0] rtype, input bit bad_sum,
                             input int break_pos, input logic [7:0] break_char);
    logic [7:0] bytes_q[$];
    logic [7:0] line[$];
    logic [7:0] sum;
    logic [7:0] c;
    bytes_q = {cnt, addr[15:8], addr[7:0], rtype};
    repeat (cnt) bytes_q.push_back(8'($urandom));
    sum = '0;
    foreach (bytes_q[i]) sum = sum + bytes_q[i];
    sum = -sum;
    if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
    bytes_q.push_back(sum);
    c = 8'h3A;
    if ($urandom_range(19) == 0) begin
      do c = 8'($urandom_range(255));
      while (c == ChCr || c == ChLf || c == ChSpace || c == ChEof);
    end
    line.push_back(c);
    foreach (bytes_q[i]) begin
      line.push_back(hex_char(bytes_q[i][7:4]));
      line.push_back(hex_char(bytes_q[i][3:0]));
    end
    if (break_pos > 0 && break_pos < line.size()) begin
      while (line.size() > break_pos) void'(line.pop_back());
      line.push_back(break_char);
      if (break_char != ChCr && break_char != ChLf) begin
        repeat ($urandom_range(4)) begin
          do c = 8'($urandom_range(255)); while (c == ChCr || c == ChLf || c == ChEof);
          line.push_back(c);
        end
      end
    end
    case ($urandom_range(3))
      0: begin
        line.push_back(ChCr);
        line.push_back(ChLf);
      end
      1: line.push_back(ChLf);
      2: line.push_back(ChCr);
      default: begin
        line.push_back(ChSpace);
        line.push_back(ChLf);
      end
    endcase
    if ($urandom_range(7) == 0) line.push_front(ChSpace);
    foreach (line[i]) send_char(line[i]);
  endtask

  task automatic send_random_record();
    int         pick;
    logic [7:0] cnt;
    logic [7:0] rtype;
    int         line_len;
    pick = $urandom_range(99);
    cnt = ($urandom_range(24) == 0) ? 8'($urandom_range(17, 255)) : 8'($urandom_range(16));
    rtype = REC_DATA;
    if (pick >= 80 && pick < 88) rtype = 8'($urandom_range(2, 255));
    if (pick < 88) begin
      send_record(cnt, 16'($urandom), rtype, pick >= 68 && pick < 80, 0, 8'h00);
    end else begin
      line_len = 1 + 2 * (cnt + 5);
      send_record(cnt, 16'($urandom), REC_DATA, 0, $urandom_range(1, line_len - 1),
                  bad_char());
    end
  endtask

  task automatic test_first_record_address();
    case ($urandom_range(2))
      0: begin
        write_expected_start(16'hFFFF);
        send_record(3, 16'h0000, REC_DATA, 0, 0, 8'h00);
      end
      1: begin
        write_expected_start(16'hFFFF);
        send_record(3, 16'hFFFF, REC_DATA, 0, 0, 8'h00);
      end
      default: begin
        write_expected_start(16'h0000);
        send_record(3, 16'($urandom), REC_DATA, 0, 0, 8'h00);
      end
    endcase
  endtask

  task automatic test_directed_records();
    send_record(0, 16'h0000, REC_DATA, 0, 0, 8'h00);
    send_record(2, 16'hFFFF, REC_DATA, 1, 0, 8'h00);
    send_record(1, 16'h8000, 8'h02, 0, 0, 8'h00);
    send_record(1, 16'h1234, 8'hFF, 0, 0, 8'h00);
    send_record(4, 16'h0010, REC_DATA, 0, 5, ChCr);
    send_record(4, 16'h0010, REC_DATA, 0, 12, 8'h47);
    send_record(2, 16'($urandom), REC_DATA, 0, 14, 8'hFF);
  endtask

  task automatic test_random_traffic();
    int          idle_set[4];
    int          stall_set[4];
    logic [15:0] start_set[4];
    int          first_char;
    idle_set = '{0, 48, 0, 16};
    stall_set = '{0, 0, 48, 16};
    start_set = '{16'h0000, 16'($urandom), 16'hFFFF, 16'h0001};
    for (int p = 0; p < 4; p++) begin
      write_expected_start(start_set[p]);
      in_idle_pct = idle_set[p];
      out_stall_pct = stall_set[p];
      first_char = chars_sent;
      while (chars_sent - first_char < PhaseChars) send_random_record();
    end
  endtask

  task automatic test_light_traffic();
    int first_char;
    wait_results_drained();
    in_idle_pct = 16;
    out_stall_pct = 16;
    first_char = chars_sent;
    while (chars_sent - first_char < 120) send_random_record();
  endtask

  task automatic test_parse_end();
    wait_results_drained();
    case ($urandom_range(3))
      0: send_record(0, 16'($urandom), REC_EOF, 0, 0, 8'h00);
      1: send_char(ChEof);
      2: send_record(4, 16'($urandom), REC_DATA, 0, $urandom_range(1, 18), ChEof);
      // end of file while skipping an ignored record
      default: send_record(4, 16'($urandom), 8'h5A, 0, $urandom_range(9, 18), ChEof);
    endcase
    repeat (24) send_char(8'($urandom));
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    test_first_record_address();
    test_directed_records();
    test_random_traffic();
    test_light_traffic();
    test_parse_end();
    wait_results_drained();
    repeat (SettleCycles) @(negedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/ihex_pkg.sv
hw/rtl/ihex_core.sv
hw/rtl/ihex_out_buf.sv
hw/rtl/intel_hex_record_parser.sv
hw/rtl/ihex_chk.sv
tb/intel_hex_record_parser_test.sv
